/* design/bicubic_bezier_patch_eval_defines.svh */
// Assertion macros used by the checker file of the patch evaluator.
// Depends on nothing; every macro takes its own clock and reset.
`ifndef BICUBIC_BEZIER_PATCH_EVAL_DEFINES_SVH
`define BICUBIC_BEZIER_PATCH_EVAL_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BBPE_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bbpe check failed");

// The consequent must hold in the cycle after the antecedent.
`define BBPE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bbpe check failed");

`endif

/* design/bbpe_pkg.sv */
// Shared types and constants of the bicubic Bezier patch evaluator.
// Depends on nothing; used by the controller, datapath and top level.
`timescale 1ns / 1ps

package bbpe_pkg;

  localparam int COORD_WIDTH_DEF     = 32;
  localparam int PARAM_FRAC_BITS_DEF = 15;

  // Control points per row and per column of the patch.
  localparam int ORDER = 4;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_EVAL  = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_RED,
    S_SAVE,
    S_LOADU,
    S_REDU,
    S_CAPT,
    S_OUT
  } bbpe_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       store_wr;
    logic       param_ld;
    logic       row_ld;
    logic [1:0] row;
    logic       res_ld;
    logic       step;
    logic       use_u;
    logic       save;
    logic       capture;
  } bbpe_cmd_t;

endpackage

/* design/bbpe_datapath.sv */
// Datapath: control point store, de Casteljau work registers, lerp units and
// result registers. Depends on bbpe_pkg for the command struct.
`timescale 1ns / 1ps

module bbpe_datapath
  import bbpe_pkg::*;
#(
  parameter int COORD_WIDTH     = COORD_WIDTH_DEF,
  parameter int PARAM_FRAC_BITS = PARAM_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  bbpe_cmd_t                     cmd_bus,
  input  logic [3:0]                    slot,
  input  logic signed [COORD_WIDTH-1:0] coord_x,
  input  logic signed [COORD_WIDTH-1:0] coord_y,
  input  logic signed [COORD_WIDTH-1:0] coord_z,
  input  logic [PARAM_FRAC_BITS:0]      u_param,
  input  logic [PARAM_FRAC_BITS:0]      v_param,
  output logic signed [COORD_WIDTH-1:0] point_x,
  output logic signed [COORD_WIDTH-1:0] point_y,
  output logic signed [COORD_WIDTH-1:0] point_z
);

  localparam int CW = COORD_WIDTH;
  localparam int F  = PARAM_FRAC_BITS;
  localparam int PW = CW + F + 3;
  localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};

  logic signed [CW-1:0] coord_in [3];
  logic signed [CW-1:0] store    [3][ORDER][ORDER];
  logic signed [CW-1:0] work     [3][ORDER];
  logic signed [CW-1:0] rowres   [3][ORDER];
  logic [F:0]           u_t;
  logic [F:0]           v_t;
  logic signed [F+1:0]  t_s;
  logic signed [CW:0]   dif      [3][3];
  logic signed [PW-1:0] prod     [3][3];
  logic signed [PW-1:0] shf      [3][3];
  logic signed [CW-1:0] lerp_q   [3][3];

  assign coord_in[0] = coord_x;
  assign coord_in[1] = coord_y;
  assign coord_in[2] = coord_z;
  assign t_s = $signed({1'b0, (cmd_bus.use_u ? u_t : v_t)});

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 3; k++) begin
        for (int r = 0; r < ORDER; r++) begin
          for (int c = 0; c < ORDER; c++) begin
            store[k][r][c] <= '0;
          end
        end
      end
    end else if (cmd_bus.store_wr) begin
      for (int k = 0; k < 3; k++) begin
        store[k][slot[3:2]][slot[1:0]] <= coord_in[k];
      end
    end
  end

  // Saturate parameters above one to exactly one.
  always_ff @(posedge clk) begin
    if (cmd_bus.param_ld) begin
      u_t <= (u_param > ONE) ? ONE : u_param;
      v_t <= (v_param > ONE) ? ONE : v_param;
    end
  end

  // lerp(a, b, t) = a + floor((b - a) * t / 2^F); the arithmetic shift floors.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int p = 0; p < 3; p++) begin
        dif[k][p]    = $signed({work[k][p+1][CW-1], work[k][p+1]})
                     - $signed({work[k][p][CW-1], work[k][p]});
        prod[k][p]   = dif[k][p] * t_s;
        shf[k][p]    = prod[k][p] >>> F;
        lerp_q[k][p] = work[k][p] + shf[k][p][CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      if (cmd_bus.row_ld) begin
        for (int c = 0; c < ORDER; c++) begin
          work[k][c] <= store[k][cmd_bus.row][c];
        end
      end else if (cmd_bus.res_ld) begin
        for (int c = 0; c < ORDER; c++) begin
          work[k][c] <= rowres[k][c];
        end
      end else if (cmd_bus.step) begin
        for (int p = 0; p < 3; p++) begin
          work[k][p] <= lerp_q[k][p];
        end
      end
      if (cmd_bus.save) begin
        rowres[k][cmd_bus.row] <= work[k][0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_bus.capture) begin
      point_x <= work[0][0];
      point_y <= work[1][0];
      point_z <= work[2][0];
    end
  end

endmodule

/* design/bbpe_ctrl.sv */
// Controller state machine: sequences row loads, reduction steps and the
// result transfer. Depends on bbpe_pkg for the state and command types.
`timescale 1ns / 1ps

module bbpe_ctrl
  import bbpe_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      cmd,
  input  logic      out_stall,
  output logic      in_stall,
  output logic      out_valid,
  output bbpe_cmd_t cmd_bus
);

  bbpe_state_t state;
  bbpe_state_t state_next;
  logic [1:0]  row;
  logic [1:0]  lvl;
  logic        in_take;

  assign in_take = in_valid && (state == S_IDLE);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (in_take && cmd == CMD_EVAL) state_next = S_LOAD;
      S_LOAD:  state_next = S_RED;
      S_RED:   if (lvl == 2'd2) state_next = S_SAVE;
      S_SAVE:  state_next = (row == 2'd3) ? S_LOADU : S_LOAD;
      S_LOADU: state_next = S_REDU;
      S_REDU:  if (lvl == 2'd2) state_next = S_CAPT;
      S_CAPT:  state_next = S_OUT;
      S_OUT:   if (!out_stall) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_bus          = '0;
    cmd_bus.row      = row;
    cmd_bus.store_wr = in_take && (cmd == CMD_WRITE);
    cmd_bus.param_ld = in_take && (cmd == CMD_EVAL);
    in_stall         = (state != S_IDLE);
    out_valid        = (state == S_OUT);
    case (state)
      S_LOAD:  cmd_bus.row_ld = 1'b1;
      S_RED:   cmd_bus.step = 1'b1;
      S_SAVE:  cmd_bus.save = 1'b1;
      S_LOADU: cmd_bus.res_ld = 1'b1;
      S_REDU: begin
        cmd_bus.step  = 1'b1;
        cmd_bus.use_u = 1'b1;
      end
      S_CAPT:  cmd_bus.capture = 1'b1;
      default: cmd_bus.step = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      row   <= '0;
      lvl   <= '0;
    end else begin
      state <= state_next;
      if (state == S_IDLE) begin
        row <= '0;
      end else if (state == S_SAVE) begin
        row <= row + 2'd1;
      end
      if (state == S_RED || state == S_REDU) begin
        lvl <= lvl + 2'd1;
      end else begin
        lvl <= '0;
      end
    end
  end

endmodule

/* design/bicubic_bezier_patch_eval.sv */
// Bicubic Bezier patch evaluator: a write transfer goes straight into the store;
// an evaluate transfer frees the input only after its result transfer, so the
// block takes no new item while an evaluation is in progress. The work is de
// Casteljau reduction: 4 rows, then one column, then a capture, through three
// shared lerp units per axis.
// Synchronous reset clears the control point store and idles the controller.
`timescale 1ns / 1ps

module bicubic_bezier_patch_eval
  import bbpe_pkg::*;
#(
  parameter int COORD_WIDTH     = COORD_WIDTH_DEF,
  parameter int PARAM_FRAC_BITS = PARAM_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          cmd,
  input  logic [3:0]                    slot,
  input  logic signed [COORD_WIDTH-1:0] coord_x,
  input  logic signed [COORD_WIDTH-1:0] coord_y,
  input  logic signed [COORD_WIDTH-1:0] coord_z,
  input  logic [PARAM_FRAC_BITS:0]      u_param,
  input  logic [PARAM_FRAC_BITS:0]      v_param,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [COORD_WIDTH-1:0] point_x,
  output logic signed [COORD_WIDTH-1:0] point_y,
  output logic signed [COORD_WIDTH-1:0] point_z
);

  // The controller walks the rows of the patch; for each row it loads four
  // control points into the work registers and applies three lerp levels
  // along v, then saves the row result. The four row results are reduced
  // along u in the same way, and the final point is held in the output
  // registers until its transfer completes. A write transfer goes straight
  // into the store while the controller is idle.
  bbpe_cmd_t cmd_bus;

  bbpe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .cmd       (cmd),
    .out_stall (out_stall),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .cmd_bus   (cmd_bus)
  );

  bbpe_datapath #(
    .COORD_WIDTH     (COORD_WIDTH),
    .PARAM_FRAC_BITS (PARAM_FRAC_BITS)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .cmd_bus (cmd_bus),
    .slot    (slot),
    .coord_x (coord_x),
    .coord_y (coord_y),
    .coord_z (coord_z),
    .u_param (u_param),
    .v_param (v_param),
    .point_x (point_x),
    .point_y (point_y),
    .point_z (point_z)
  );

endmodule

/* design/bbpe_checker.sv */
// Port-level checker for the patch evaluator, bound to the top level.
// Depends on the assertion macros header and bbpe_pkg for defaults.
`timescale 1ns / 1ps
`include "bicubic_bezier_patch_eval_defines.svh"

module bbpe_checker
  import bbpe_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   in_valid,
  input logic                   in_stall,
  input logic                   cmd,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic [COORD_WIDTH-1:0] point_x
);

  `BBPE_ASSERT_SAME(a_busy_out, clk, rst, out_valid, in_stall)
  `BBPE_ASSERT_NEXT(a_eval_busy, clk, rst, in_valid && !in_stall && cmd, in_stall && !out_valid)
  `BBPE_ASSERT_NEXT(a_write_free, clk, rst, in_valid && !in_stall && !cmd, !in_stall)
  `BBPE_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(point_x))

endmodule

bind bicubic_bezier_patch_eval bbpe_checker #(.COORD_WIDTH(COORD_WIDTH)) u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .cmd       (cmd),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .point_x   (point_x)
);

/* sim/bicubic_bezier_patch_eval_test.sv */
// Self-checking testbench for the bicubic Bezier patch evaluator.
// Depends on bbpe_pkg and the top level bicubic_bezier_patch_eval.
`timescale 1ns / 1ps

module bicubic_bezier_patch_eval_test;
  import bbpe_pkg::*;

  localparam int CW = COORD_WIDTH_DEF;
  localparam int PF = PARAM_FRAC_BITS_DEF;
  localparam longint PONE = 64'sd1 <<< PF;

  typedef struct packed {
    logic          op;
    logic [3:0]    slot;
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic [CW-1:0] z;
    logic [PF:0]   u;
    logic [PF:0]   v;
  } bbpe_item_t;

  typedef struct packed {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic [CW-1:0] z;
  } surf_point_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic cmd = CMD_WRITE;
  logic [3:0] slot = '0;
  logic signed [CW-1:0] coord_x = '0, coord_y = '0, coord_z = '0;
  logic [PF:0] u_param = '0, v_param = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [CW-1:0] point_x, point_y, point_z;

  bicubic_bezier_patch_eval u_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .cmd(cmd),
    .slot(slot), .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
    .u_param(u_param), .v_param(v_param), .out_valid(out_valid),
    .out_stall(out_stall), .point_x(point_x), .point_y(point_y), .point_z(point_z)
  );

  always #6 clk = ~clk;

  // The predictor's own copy of the control point store.
  longint patch_x[16], patch_y[16], patch_z[16];

  bbpe_item_t  pending_items[$];
  surf_point_t expected_points[$];
  int  mismatches = 0;
  bit  calm = 1'b0;
  int  in_gap = 0, out_gap = 0;

  // Floor division by 2^PF, written so that no negative value is shifted.
  function automatic longint floor_frac(longint d);
    if (d >= 0) return d >>> PF;
    return -((-d - 1) >>> PF) - 1;
  endfunction

  function automatic longint lerp_q(longint a, longint b, longint t);
    longint d, hi, lo;
    d = b - a;
    hi = floor_frac(d);
    lo = d - hi * PONE;
    return a + hi * t + ((lo * t) >>> PF);
  endfunction

  function automatic longint casteljau4(longint p0, longint p1, longint p2, longint p3,
                                        longint t);
    longint a, b, c;
    a = lerp_q(p0, p1, t);
    b = lerp_q(p1, p2, t);
    c = lerp_q(p2, p3, t);
    return lerp_q(lerp_q(a, b, t), lerp_q(b, c, t), t);
  endfunction

  function automatic longint surface_coord(longint p[16], longint u, longint v);
    longint r[4];
    for (int i = 0; i < 4; i++)
      r[i] = casteljau4(p[i*4], p[i*4+1], p[i*4+2], p[i*4+3], v);
    return casteljau4(r[0], r[1], r[2], r[3], u);
  endfunction

  // Appends one item to the queue of pending items.
  task automatic queue_item(bbpe_item_t it);
    pending_items = {pending_items, it};
  endtask

  // Updates the store on a write, or queues the surface point of an evaluate.
  task automatic predict_point(bbpe_item_t it);
    longint u, v;
    surf_point_t sp;
    if (it.op == CMD_WRITE) begin
      patch_x[it.slot] = longint'(signed'(it.x));
      patch_y[it.slot] = longint'(signed'(it.y));
      patch_z[it.slot] = longint'(signed'(it.z));
    end else begin
      u = (longint'(it.u) > PONE) ? PONE : longint'(it.u);
      v = (longint'(it.v) > PONE) ? PONE : longint'(it.v);
      sp.x = CW'(surface_coord(patch_x, u, v));
      sp.y = CW'(surface_coord(patch_y, u, v));
      sp.z = CW'(surface_coord(patch_z, u, v));
      expected_points = {expected_points, sp};
    end
  endtask

  function automatic bbpe_item_t random_item(bit op, bit wide);
    bbpe_item_t it;
    it.op = op;
    it.slot = 4'($urandom_range(0, 15));
    it.x = $urandom; it.y = $urandom; it.z = $urandom;
    if (!wide) begin
      // Mostly modest coordinates so that surfaces look like surfaces.
      it.x = signed'(it.x) >>> $urandom_range(0, 16);
      it.y = signed'(it.y) >>> $urandom_range(0, 16);
      it.z = signed'(it.z) >>> $urandom_range(0, 16);
    end
    case ($urandom_range(0, 9))
      0: begin it.u = (PF+1)'($urandom); it.v = (PF+1)'($urandom); end
      1: begin it.u = (PF+1)'(PONE); it.v = (PF+1)'($urandom_range(0, 1)); end
      default: begin
        it.u = (PF+1)'($urandom_range(0, 32'(PONE)));
        it.v = (PF+1)'($urandom_range(0, 32'(PONE)));
      end
    endcase
    return it;
  endfunction

  // Driver: a transfer happens at an edge where valid is high and stall low.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        bbpe_item_t it;
        it = pending_items.pop_front();
        predict_point(it);
        cmd <= it.op; slot <= it.slot;
        coord_x <= it.x; coord_y <= it.y; coord_z <= it.z;
        u_param <= it.u; v_param <= it.v;
        in_valid <= 1'b1;
        if (!calm && $urandom_range(0, 7) == 0) in_gap <= $urandom_range(1, 12);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: checks each result transfer and keeps the stall bursts going.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_points.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h %h %h", point_x, point_y,
                                         point_z);
        end else begin
          surf_point_t e;
          e = expected_points.pop_front();
          if (e.x !== point_x || e.y !== point_y || e.z !== point_z) begin
            mismatches++;
            if (mismatches <= 10)
              $display("point mismatch: expected %h %h %h, got %h %h %h",
                       e.x, e.y, e.z, point_x, point_y, point_z);
          end
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        out_gap <= $urandom_range(0, 11);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    bbpe_item_t it;
    int n;
    for (int i = 0; i < 16; i++) begin
      patch_x[i] = 0; patch_y[i] = 0; patch_z[i] = 0;
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed part: evaluate the cleared store, write extremes to corners and slot 5,
    // then the parameter corners, saturation, and high unused fields.
    it = '0; it.op = CMD_EVAL; it.u = (PF+1)'(PONE); it.v = (PF+1)'(PONE); queue_item(it);
    it = '0; it.op = CMD_WRITE; it.slot = 0; it.x = 32'h8000_0000; it.y = 32'h7fff_ffff;
    it.z = 32'hffff_ffff; it.u = '1; it.v = '1; queue_item(it);
    it.slot = 15; it.x = 32'h7fff_ffff; it.y = 32'h8000_0000; it.z = 32'h0000_0001;
    queue_item(it);
    it.slot = 5; it.x = 32'h8000_0000; it.y = 32'h8000_0000; it.z = 32'h7fff_ffff;
    queue_item(it);
    for (int k = 0; k < 8; k++) begin
      it = '0; it.op = CMD_EVAL;
      it.slot = 4'hf; it.x = '1; it.y = '1; it.z = '1;
      it.u = (PF+1)'((k[0]) ? PONE : 0); it.v = (PF+1)'((k[1]) ? PONE : 0);
      if (k >= 4) begin
        it.u = {(PF+1){1'b1}} - (PF+1)'(k);
        it.v = (PF+1)'(PONE + k);
      end
      queue_item(it);
    end
    it = '0; it.op = CMD_EVAL; it.u = 1; it.v = (PF+1)'(PONE - 1); queue_item(it);
    it.u = (PF+1)'(PONE >> 1); it.v = (PF+1)'(PONE >> 1); queue_item(it);

    // Random part: patches rebuilt in whole and in part between evaluations.
    n = pending_items.size();
    while (n < 1600) begin
      if ($urandom_range(0, 3) == 0) begin
        for (int s = 0; s < 16; s++) begin
          it = random_item(CMD_WRITE, $urandom_range(0, 3) == 0);
          it.slot = 4'(s);
          queue_item(it);
        end
        n += 16;
      end
      repeat ($urandom_range(1, 4)) begin
        it = random_item($urandom_range(0, 2) != 0, 1'b0);
        queue_item(it);
        n++;
      end
      if (n > 1450) calm = 1'b1;
      while (pending_items.size() > 40) @(posedge clk);
    end
    while (pending_items.size() > 0 || in_valid) @(posedge clk);
    while (expected_points.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("bicubic_bezier_patch_eval_test passed");
    end else begin
      $display("bicubic_bezier_patch_eval_test failed");
    end
    $finish;
  end

  // Watchdog: fails the run if it has not finished before this delay ends; the delay leaves ample room.
  initial begin
    #(12 * 400000);
    $display("bicubic_bezier_patch_eval_test failed");
    $finish;
  end

endmodule
